// ===== hw/rtl/bkd_pkg.sv =====
// Shared types and constants of the ball kick detector.
`timescale 1ns / 1ps
package bkd_pkg;

  // Item kinds on the input channel; code 3 carries no meaning
  typedef enum logic [1:0] {
    MODE_BALL  = 2'd0,
    MODE_ROBOT = 2'd1,
    MODE_END   = 2'd2
  } mode_t;

  // Register map: index is paddr[2] (one 32-bit register per word)
  localparam int          PADDR_W        = 3;
  localparam logic [0:0]  REG_JUMP_THR   = 1'b0;
  localparam logic [15:0] JUMP_THR_RESET = 16'd625;

  localparam logic [33:0] DIST_ALL_ONES  = '1;

  // One history frame: ball observation plus nearest robot so far
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               ball_ok;
    logic [31:0]        ts;
    logic               found;
    logic               team;
    logic [3:0]         num;
  } frame_t;

  // Snapshot of the history handed to the kick test on a frame end
  typedef struct packed {
    logic               ok;      // history full and every ball valid
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] xp;      // second newest
    logic signed [15:0] yp;
    logic signed [15:0] xn;      // newest
    logic signed [15:0] yn;
    logic [31:0]        mid_ts;
    logic               mid_found;
    logic               mid_team;
    logic [3:0]         mid_num;
  } eval_req_t;

endpackage

// ===== hw/rtl/bkd_if.sv =====
// Item and result channel interfaces of the ball kick detector.
`timescale 1ns / 1ps
interface bkd_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               obj_valid;
  logic               team;
  logic [3:0]         robot_num;
  logic [31:0]        timestamp;

  modport source (output valid, mode, pos_x, pos_y, obj_valid, team, robot_num, timestamp,
                  input ready);
  modport sink   (input valid, mode, pos_x, pos_y, obj_valid, team, robot_num, timestamp,
                  output ready);
endinterface

interface bkd_result_if;
  logic        valid;
  logic        ready;
  logic        kick_detected;
  logic [31:0] kick_stamp;
  logic        kicker_found;
  logic        kicker_team;
  logic [3:0]  kicker_num;

  modport source (output valid, kick_detected, kick_stamp, kicker_found, kicker_team,
                  kicker_num, input ready);
  modport sink   (input valid, kick_detected, kick_stamp, kicker_found, kicker_team,
                  kicker_num, output ready);
endinterface

// ===== hw/rtl/bkd_cell.sv =====
// One history cell: holds a frame, shifts it to the older neighbour and records a nearest-robot update.
`timescale 1ns / 1ps
module bkd_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift_en,
  input  bkd_pkg::frame_t shift_in,
  input  logic            upd_en,
  input  logic            upd_team,
  input  logic [3:0]      upd_num,
  output bkd_pkg::frame_t frame
);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else if (shift_en) begin
      frame <= shift_in;
    end else if (upd_en) begin
      frame.found <= 1'b1;
      frame.team  <= upd_team;
      frame.num   <= upd_num;
    end
  end

endmodule

// ===== hw/rtl/bkd_kick_eval.sv =====
// Kick test pipeline: differences, squares, then compare into the output register.
`timescale 1ns / 1ps
module bkd_kick_eval (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  bkd_pkg::eval_req_t req,
  input  logic [15:0]        jump_threshold,
  bkd_result_if.source       results
);

  // difference stage
  logic               d_v;
  logic               d_ok;
  logic signed [16:0] d_sx, d_sy, d_ex, d_ey;
  logic signed [17:0] d_ddx, d_ddy;
  logic [31:0]        d_ts;
  logic               d_found, d_team;
  logic [3:0]         d_num;
  // square stage
  logic               s_v;
  logic               s_ok;
  logic [33:0]        s_sx2, s_sy2, s_ex2, s_ey2;
  logic [35:0]        s_ddx2, s_ddy2;
  logic [31:0]        s_thr2;
  logic [31:0]        s_ts;
  logic               s_found, s_team;
  logic [3:0]         s_num;

  logic               d_ready, s_ready, o_ready;
  logic signed [16:0] sx, sy, ex, ey;
  logic signed [33:0] m_sx, m_sy, m_ex, m_ey;
  logic signed [35:0] m_ddx, m_ddy;
  logic [36:0]        change;
  logic [34:0]        first_sq, last_sq;
  logic               kick;

  assign o_ready   = !results.valid || results.ready;
  assign s_ready   = !s_v || o_ready;
  assign d_ready   = !d_v || s_ready;
  assign req_ready = d_ready;

  assign sx = {req.x1[15], req.x1} - {req.x0[15], req.x0};
  assign sy = {req.y1[15], req.y1} - {req.y0[15], req.y0};
  assign ex = {req.xn[15], req.xn} - {req.xp[15], req.xp};
  assign ey = {req.yn[15], req.yn} - {req.yp[15], req.yp};

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (d_ready) begin
      d_v <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && req_valid) begin
      d_ok    <= req.ok;
      d_sx    <= sx;
      d_sy    <= sy;
      d_ex    <= ex;
      d_ey    <= ey;
      d_ddx   <= {ex[16], ex} - {sx[16], sx};
      d_ddy   <= {ey[16], ey} - {sy[16], sy};
      d_ts    <= req.mid_ts;
      d_found <= req.mid_found;
      d_team  <= req.mid_team;
      d_num   <= req.mid_num;
    end
  end

  assign m_sx  = 34'(d_sx) * 34'(d_sx);
  assign m_sy  = 34'(d_sy) * 34'(d_sy);
  assign m_ex  = 34'(d_ex) * 34'(d_ex);
  assign m_ey  = 34'(d_ey) * 34'(d_ey);
  assign m_ddx = 36'(d_ddx) * 36'(d_ddx);
  assign m_ddy = 36'(d_ddy) * 36'(d_ddy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else if (s_ready) begin
      s_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && d_v) begin
      s_ok    <= d_ok;
      s_sx2   <= $unsigned(m_sx);
      s_sy2   <= $unsigned(m_sy);
      s_ex2   <= $unsigned(m_ex);
      s_ey2   <= $unsigned(m_ey);
      s_ddx2  <= $unsigned(m_ddx);
      s_ddy2  <= $unsigned(m_ddy);
      s_thr2  <= {16'd0, jump_threshold} * {16'd0, jump_threshold};
      s_ts    <= d_ts;
      s_found <= d_found;
      s_team  <= d_team;
      s_num   <= d_num;
    end
  end

  assign change   = {1'b0, s_ddx2} + {1'b0, s_ddy2};
  assign first_sq = {1'b0, s_sx2} + {1'b0, s_sy2};
  assign last_sq  = {1'b0, s_ex2} + {1'b0, s_ey2};
  assign kick     = s_ok && (change > {5'b0, s_thr2}) && (first_sq < last_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (o_ready) begin
      results.valid <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && s_v) begin
      results.kick_detected <= kick;
      results.kick_stamp    <= kick ? s_ts : 32'd0;
      results.kicker_found  <= kick && s_found;
      results.kicker_team   <= kick && s_found && s_team;
      results.kicker_num    <= (kick && s_found) ? s_num : 4'd0;
    end
  end

  // a beat stalled at the output must not be overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=> results.valid && $stable(results.kick_stamp))
    else $error("result beat overwritten while stalled");

  // no kick without a full, valid history
  a_kick_ok: assert property (@(posedge clk) disable iff (rst)
    o_ready && s_v && !s_ok |=> !results.kick_detected)
    else $error("kick flagged on incomplete history");

endmodule

// ===== hw/rtl/ball_kick_detector.sv =====
// Top level of the ball kick detector: apply stage, history cell row and kick test.
//
//   channel   dir   handshake          beat
//   items     in    valid/ready        ball, robot or frame-end observation
//   results   out   valid/ready        kick verdict, one per frame end
//   apb       in    psel/penable       jump_threshold write and read, pready tied high
//
// One item is taken every cycle while no frame end waits in the apply register. Ball and
// robot items take effect in the cycle after acceptance, from the apply register; the robot
// distance squares are formed on the way in. A frame end passes the apply register, then
// the difference, square and output registers, to its result. A stalled result holds the
// kick pipeline; three frame ends fit in it and a fourth waits in the apply register, then
// items are held back. rst clears history, fill count and the best distance, and sets
// jump_threshold to 625.
`timescale 1ns / 1ps
module ball_kick_detector #(
  parameter int HIST_LEN = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  bkd_item_if.sink                    items,
  bkd_result_if.source                results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bkd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int FILL_W = $clog2(HIST_LEN + 1);
  localparam int MID    = HIST_LEN / 2;
  localparam int NEWEST = HIST_LEN - 1;

  logic [15:0]        jump_threshold;

  // apply register
  logic               a_v;
  logic [1:0]         a_mode;
  logic signed [15:0] a_x, a_y;
  logic               a_ov, a_team;
  logic [3:0]         a_num;
  logic [31:0]        a_ts;
  logic [33:0]        a_sqx, a_sqy;

  logic [33:0]        cur_best_dist;
  logic [FILL_W-1:0]  fill_count;

  bkd_pkg::frame_t    cells [HIST_LEN];
  bkd_pkg::frame_t    new_frame;
  bkd_pkg::eval_req_t req;
  logic [HIST_LEN-1:0] ball_oks;

  logic               a_fire, a_ball, a_robot, a_end;
  logic               eval_ready, near_upd, full;
  logic signed [15:0] fwd_x, fwd_y;
  logic signed [16:0] dx, dy;
  logic signed [33:0] m_dx, m_dy;
  logic [33:0]        robot_dist;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bkd_pkg::REG_JUMP_THR) ? {16'd0, jump_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold <= bkd_pkg::JUMP_THR_RESET;
    end else if (psel && penable && pwrite && paddr[2] == bkd_pkg::REG_JUMP_THR) begin
      jump_threshold <= pwdata[15:0];
    end
  end

  assign a_ball  = a_mode == bkd_pkg::MODE_BALL;
  assign a_robot = a_mode == bkd_pkg::MODE_ROBOT;
  assign a_end   = a_mode == bkd_pkg::MODE_END;
  assign a_fire  = a_v && (!a_end || eval_ready);
  assign items.ready = !a_v || a_fire;

  // a ball in the apply register lands in the newest cell at this edge
  assign fwd_x = (a_v && a_ball) ? a_x : cells[NEWEST].x;
  assign fwd_y = (a_v && a_ball) ? a_y : cells[NEWEST].y;
  assign dx    = {fwd_x[15], fwd_x} - {items.pos_x[15], items.pos_x};
  assign dy    = {fwd_y[15], fwd_y} - {items.pos_y[15], items.pos_y};
  assign m_dx  = 34'(dx) * 34'(dx);
  assign m_dy  = 34'(dy) * 34'(dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (items.ready) begin
      a_v <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      a_mode <= items.mode;
      a_x    <= items.pos_x;
      a_y    <= items.pos_y;
      a_ov   <= items.obj_valid;
      a_team <= items.team;
      a_num  <= items.robot_num;
      a_ts   <= items.timestamp;
      a_sqx  <= $unsigned(m_dx);
      a_sqy  <= $unsigned(m_dy);
    end
  end

  assign robot_dist = a_sqx + a_sqy;
  assign full       = fill_count == FILL_W'(HIST_LEN);
  assign near_upd   = a_fire && a_robot && (fill_count != '0) && a_ov &&
                      (robot_dist < cur_best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_best_dist <= bkd_pkg::DIST_ALL_ONES;
      fill_count    <= '0;
    end else begin
      if (a_fire && a_ball) begin
        cur_best_dist <= bkd_pkg::DIST_ALL_ONES;
        if (!full) begin
          fill_count <= fill_count + 1'b1;
        end
      end else if (near_upd) begin
        cur_best_dist <= robot_dist;
      end
    end
  end

  always_comb begin
    new_frame         = '0;
    new_frame.x       = a_x;
    new_frame.y       = a_y;
    new_frame.ball_ok = a_ov;
    new_frame.ts      = a_ts;
  end

  for (genvar i = 0; i < HIST_LEN; i++) begin : g_cell
    if (i == NEWEST) begin : g_newest
      bkd_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (a_fire && a_ball),
        .shift_in (new_frame),
        .upd_en   (near_upd),
        .upd_team (a_team),
        .upd_num  (a_num),
        .frame    (cells[i])
      );
    end else begin : g_older
      bkd_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (a_fire && a_ball),
        .shift_in (cells[i+1]),
        .upd_en   (1'b0),
        .upd_team (1'b0),
        .upd_num  (4'd0),
        .frame    (cells[i])
      );
    end
    assign ball_oks[i] = cells[i].ball_ok;
  end

  always_comb begin
    req           = '0;
    req.ok        = full && (&ball_oks);
    req.x0        = cells[0].x;
    req.y0        = cells[0].y;
    req.x1        = cells[1].x;
    req.y1        = cells[1].y;
    req.xp        = cells[NEWEST-1].x;
    req.yp        = cells[NEWEST-1].y;
    req.xn        = cells[NEWEST].x;
    req.yn        = cells[NEWEST].y;
    req.mid_ts    = cells[MID].ts;
    req.mid_found = cells[MID].found;
    req.mid_team  = cells[MID].team;
    req.mid_num   = cells[MID].num;
  end

  bkd_kick_eval u_eval (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (a_v && a_end),
    .req_ready      (eval_ready),
    .req            (req),
    .jump_threshold (jump_threshold),
    .results        (results)
  );

  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(HIST_LEN))
    else $error("fill count beyond history length");

  a_ball_fill: assert property (@(posedge clk) disable iff (rst)
    a_fire && a_ball && !full |=> fill_count == $past(fill_count) + 1'b1)
    else $error("ball beat did not grow the history");

  a_ball_best: assert property (@(posedge clk) disable iff (rst)
    a_fire && a_ball |=> cur_best_dist == bkd_pkg::DIST_ALL_ONES && !cells[NEWEST].found)
    else $error("new frame kept a stale nearest robot");

  a_near_upd: assert property (@(posedge clk) disable iff (rst)
    near_upd |=> cells[NEWEST].found && cur_best_dist == $past(robot_dist))
    else $error("nearest robot update lost");

endmodule

// ===== tb/sv/bkd_kick_checker.sv =====
// Kick detector checker: tracks the item stream, predicts each frame-end verdict and compares.
`timescale 1ns / 1ps
module bkd_kick_checker #(
  parameter int HIST_LEN = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  bkd_item_if                         items,
  bkd_result_if                       results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bkd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending
);

  localparam int MID = HIST_LEN / 2;

  typedef struct packed {
    logic        kick;
    logic [31:0] kick_stamp;
    logic        found;
    logic        team;
    logic [3:0]  num;
  } verdict_t;

  bkd_pkg::frame_t hist [HIST_LEN];
  logic [33:0]     best_dist;
  int              frames_held;
  logic [15:0]     jump_thr;
  verdict_t        verdicts_due [$];

  function automatic void clear_history();
    for (int i = 0; i < HIST_LEN; i++) hist[i] = '0;
    best_dist   = bkd_pkg::DIST_ALL_ONES;
    frames_held = 0;
    jump_thr    = bkd_pkg::JUMP_THR_RESET;
  endfunction

  function automatic void push_ball(logic signed [15:0] x, logic signed [15:0] y, logic ok,
                                    logic [31:0] ts);
    for (int i = 0; i + 1 < HIST_LEN; i++) hist[i] = hist[i + 1];
    hist[HIST_LEN-1]         = '0;
    hist[HIST_LEN-1].x       = x;
    hist[HIST_LEN-1].y       = y;
    hist[HIST_LEN-1].ball_ok = ok;
    hist[HIST_LEN-1].ts      = ts;
    best_dist = bkd_pkg::DIST_ALL_ONES;
    if (frames_held < HIST_LEN) frames_held++;
  endfunction

  function automatic void offer_robot(logic signed [15:0] x, logic signed [15:0] y, logic ok,
                                      logic tm, logic [3:0] rn);
    longint dx, dy, d;
    if (frames_held > 0 && ok) begin
      dx = longint'(hist[HIST_LEN-1].x) - longint'(x);
      dy = longint'(hist[HIST_LEN-1].y) - longint'(y);
      d  = dx * dx + dy * dy;
      // strict compare: on a tie the earlier robot stays
      if (d < longint'(best_dist)) begin
        best_dist = d[33:0];
        hist[HIST_LEN-1].found = 1'b1;
        hist[HIST_LEN-1].team  = tm;
        hist[HIST_LEN-1].num   = rn;
      end
    end
  endfunction

  function automatic verdict_t judge_frame_end();
    verdict_t v;
    logic     all_ok;
    longint   sx, sy, ex, ey, change, thr_sq;
    v = '0;
    if (frames_held >= HIST_LEN) begin
      all_ok = 1'b1;
      for (int i = 0; i < HIST_LEN; i++) if (!hist[i].ball_ok) all_ok = 1'b0;
      if (all_ok) begin
        sx = longint'(hist[1].x) - longint'(hist[0].x);
        sy = longint'(hist[1].y) - longint'(hist[0].y);
        ex = longint'(hist[HIST_LEN-1].x) - longint'(hist[HIST_LEN-2].x);
        ey = longint'(hist[HIST_LEN-1].y) - longint'(hist[HIST_LEN-2].y);
        change = (ex - sx) * (ex - sx) + (ey - sy) * (ey - sy);
        thr_sq = longint'(jump_thr) * longint'(jump_thr);
        if (change > thr_sq && sx * sx + sy * sy < ex * ex + ey * ey) begin
          v.kick       = 1'b1;
          v.kick_stamp = hist[MID].ts;
          v.found      = hist[MID].found;
          v.team       = hist[MID].found ? hist[MID].team : 1'b0;
          v.num        = hist[MID].found ? hist[MID].num : 4'd0;
        end
      end
    end
    return v;
  endfunction

  initial begin
    fail_count = 0;
    clear_history();
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      clear_history();
      verdicts_due.delete();
    end else begin
      if (psel && penable && pready &&
          paddr[bkd_pkg::PADDR_W-1:2] == bkd_pkg::REG_JUMP_THR) begin
        if (pwrite) begin
          jump_thr = pwdata[15:0];
        end else if (prdata[15:0] !== jump_thr) begin
          $error("jump_threshold: expected %0d, got %0d", jump_thr, prdata[15:0]);
          fail_count = fail_count + 1;
        end
      end

      if (results.valid && results.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result beat with no frame end outstanding");
          fail_count = fail_count + 1;
        end else begin
          want = verdicts_due[0];
          verdicts_due.delete(0);
          if (results.kick_detected !== want.kick) begin
            $error("kick_detected: expected %0d, got %0d", want.kick, results.kick_detected);
            fail_count = fail_count + 1;
          end
          if (results.kick_stamp !== want.kick_stamp) begin
            $error("kick_stamp: expected %0h, got %0h", want.kick_stamp, results.kick_stamp);
            fail_count = fail_count + 1;
          end
          if (results.kicker_found !== want.found) begin
            $error("kicker_found: expected %0d, got %0d", want.found, results.kicker_found);
            fail_count = fail_count + 1;
          end
          if (results.kicker_team !== want.team) begin
            $error("kicker_team: expected %0d, got %0d", want.team, results.kicker_team);
            fail_count = fail_count + 1;
          end
          if (results.kicker_num !== want.num) begin
            $error("kicker_num: expected %0d, got %0d", want.num, results.kicker_num);
            fail_count = fail_count + 1;
          end
        end
      end

      if (items.valid && items.ready) begin
        case (items.mode)
          bkd_pkg::MODE_BALL:  push_ball(items.pos_x, items.pos_y, items.obj_valid,
                                         items.timestamp);
          bkd_pkg::MODE_ROBOT: offer_robot(items.pos_x, items.pos_y, items.obj_valid,
                                           items.team, items.robot_num);
          bkd_pkg::MODE_END:   verdicts_due.push_back(judge_frame_end());
          default: ;
        endcase
      end
    end
    pending <= verdicts_due.size();
  end

endmodule

// ===== tb/sv/ball_kick_detector_tb.sv =====
// Testbench top of the ball kick detector: clock, reset, stimulus, register writes and reads, and verdict.
`timescale 1ns / 1ps
module ball_kick_detector_tb;

  localparam int HIST_LEN    = 3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_GAP   = 10;

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [bkd_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  int                          fail_count;
  int                          pending;
  int                          cycles;
  bit                          idle_on;
  int                          items_sent;

  // ball trajectory of the random part
  logic signed [15:0]   ball_x, ball_y;
  int                   vel_x, vel_y;

  bkd_item_if   items ();
  bkd_result_if results ();

  ball_kick_detector #(.HIST_LEN(HIST_LEN)) u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items.sink),
    .results (results.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bkd_kick_checker #(.HIST_LEN(HIST_LEN)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .results    (results),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // result side back-pressure
  initial begin
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(posedge clk);
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [1:0] m, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic ok, input logic tm,
                           input logic [3:0] rn, input logic [31:0] ts);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    items.valid     <= 1'b1;
    items.mode      <= m;
    items.pos_x     <= x;
    items.pos_y     <= y;
    items.obj_valid <= ok;
    items.team      <= tm;
    items.robot_num <= rn;
    items.timestamp <= ts;
    do @(posedge clk); while (!items.ready);
    items_sent++;
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {bkd_pkg::REG_JUMP_THR, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    items.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic send_noise();
    send_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 1'($urandom),
              1'($urandom), 4'($urandom), $urandom);
  endtask

  // one camera frame: ball, a few robots around it, usually a frame end
  task automatic send_frame();
    int                 n_robots;
    int                 off;
    logic signed [15:0] rx, ry;
    logic               rok;
    if ($urandom_range(0, 6) == 0) begin
      // kick: sudden jump in per-frame displacement
      if ($urandom_range(0, 3) == 0) begin
        vel_x = int'($urandom_range(0, 65535)) - 32768;
        vel_y = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        vel_x = int'($urandom_range(0, 8000)) - 4000;
        vel_y = int'($urandom_range(0, 8000)) - 4000;
      end
    end else if ($urandom_range(0, 3) == 0) begin
      vel_x = int'($urandom_range(0, 100)) - 50;
      vel_y = int'($urandom_range(0, 100)) - 50;
    end
    ball_x = ball_x + 16'(vel_x);
    ball_y = ball_y + 16'(vel_y);
    send_item(bkd_pkg::MODE_BALL, ball_x, ball_y, $urandom_range(0, 15) != 0, 1'($urandom),
              4'($urandom), $urandom);
    n_robots = $urandom_range(0, 4);
    rx = ball_x;
    ry = ball_y;
    for (int i = 0; i < n_robots; i++) begin
      // sometimes reuse the previous spot so the distances tie
      if (i == 0 || $urandom_range(0, 5) != 0) begin
        off = int'($urandom_range(0, 1200)) - 600;
        rx  = ball_x + 16'(off);
        off = int'($urandom_range(0, 1200)) - 600;
        ry  = ball_y + 16'(off);
      end
      rok = $urandom_range(0, 7) != 0;
      send_item(bkd_pkg::MODE_ROBOT, rx, ry, rok, 1'($urandom), 4'($urandom), $urandom);
    end
    if ($urandom_range(0, 15) != 0) begin
      send_item(bkd_pkg::MODE_END, 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                4'($urandom), $urandom);
      if ($urandom_range(0, 19) == 0)
        send_item(bkd_pkg::MODE_END, '0, '0, 1'b0, 1'b0, 4'd0, '0);
    end
  endtask

  task automatic run_random(input int n_items, input bit idle_allowed);
    int goal;
    goal = items_sent + n_items;
    idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
    while (items_sent < goal) begin
      if (items_sent % 40 == 0) idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_frame();
    end
  endtask

  initial begin
    logic [15:0] thr_set [6];
    thr_set = '{16'd625, 16'd0, 16'd65535, 16'd0, 16'd1500, 16'd100};
    thr_set[3] = 16'($urandom);

    rst             <= 1'b1;
    idle_on          = 1'b0;
    items_sent       = 0;
    ball_x           = '0;
    ball_y           = '0;
    vel_x            = 0;
    vel_y            = 0;
    items.valid     <= 1'b0;
    items.mode      <= bkd_pkg::MODE_BALL;
    items.pos_x     <= '0;
    items.pos_y     <= '0;
    items.obj_valid <= 1'b0;
    items.team      <= 1'b0;
    items.robot_num <= '0;
    items.timestamp <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, threshold at its reset value
    idle_on = 1'b1;
    send_item(bkd_pkg::MODE_ROBOT, 16'sd5, 16'sd5, 1'b1, 1'b1, 4'd7, '0);   // no frame yet
    send_item(bkd_pkg::MODE_END, '0, '0, 1'b0, 1'b0, 4'd0, '0);             // history empty
    send_item(2'd3, -16'sd1, -16'sd1, 1'b1, 1'b1, 4'd15, '1);               // meaningless code
    send_item(bkd_pkg::MODE_BALL, 16'sd0, 16'sd0, 1'b1, 1'b0, 4'd0, 32'd100);
    send_item(bkd_pkg::MODE_ROBOT, 16'sd100, 16'sd0, 1'b1, 1'b0, 4'd3, '0);
    send_item(bkd_pkg::MODE_ROBOT, 16'sd0, 16'sd100, 1'b1, 1'b1, 4'd5, '0); // tie, first stays
    send_item(bkd_pkg::MODE_ROBOT, 16'sd0, 16'sd0, 1'b0, 1'b1, 4'd1, '0);   // invalid robot
    send_item(bkd_pkg::MODE_END, '0, '0, 1'b0, 1'b0, 4'd0, '0);
    send_item(bkd_pkg::MODE_BALL, 16'sd10, 16'sd0, 1'b1, 1'b0, 4'd0, 32'd200);
    send_item(bkd_pkg::MODE_ROBOT, 16'sd10, 16'sd5, 1'b1, 1'b1, 4'd15, '0);
    send_item(bkd_pkg::MODE_ROBOT, 16'sd10, 16'sd3, 1'b1, 1'b0, 4'd0, '0);  // nearer one wins
    send_item(bkd_pkg::MODE_END, '0, '0, 1'b0, 1'b0, 4'd0, '0);
    send_item(bkd_pkg::MODE_BALL, 16'sd2000, 16'sd0, 1'b1, 1'b0, 4'd0, 32'd300);
    send_item(bkd_pkg::MODE_END, '0, '0, 1'b0, 1'b0, 4'd0, '0);             // kick
    send_item(bkd_pkg::MODE_END, '0, '0, 1'b0, 1'b0, 4'd0, '0);             // same history
    send_item(bkd_pkg::MODE_ROBOT, 16'sd2000, 16'sd1, 1'b1, 1'b1, 4'd9, '0); // after frame end
    send_item(bkd_pkg::MODE_BALL, -16'sd32768, -16'sd32768, 1'b1, 1'b0, 4'd0, 32'hFFFF_FFFF);
    send_item(bkd_pkg::MODE_ROBOT, 16'sd32767, 16'sd32767, 1'b1, 1'b1, 4'd15, '0); // widest
    send_item(bkd_pkg::MODE_BALL, 16'sd32767, 16'sd32767, 1'b1, 1'b0, 4'd0, '0); // no end
    send_item(bkd_pkg::MODE_END, '0, '0, 1'b0, 1'b0, 4'd0, '0);
    send_item(bkd_pkg::MODE_BALL, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd0, 32'd400); // invalid ball
    send_item(bkd_pkg::MODE_END, '0, '0, 1'b0, 1'b0, 4'd0, '0);
    send_item(bkd_pkg::MODE_ROBOT, -16'sd32768, 16'sd32767, 1'b1, 1'b1, 4'd15, '1);
    send_item(bkd_pkg::MODE_END, '1, '1, 1'b1, 1'b1, 4'd15, '1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      apb_access(1'b1, {16'd0, thr_set[ph]});
      apb_access(1'b0, '0);
      if (ph == 5) begin
        run_random(40, 1'b1);
        run_random(150, 1'b0);
      end else begin
        run_random(190, 1'b1);
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
